// ----- rtl/eaq_pkg.sv -----
// Shared constants, types and the arctangent table for the Euler angle to
// quaternion block. No dependencies.
package eaq_pkg;

  localparam int ANGLE_BITS_DEF     = 16;
  localparam int QUAT_FRAC_BITS_DEF = 15;
  localparam int CORDIC_STEPS_DEF   = 16;

  localparam int IN_W    = 17;   // input angle field width
  localparam int QUAT_W  = 16;   // output component width
  localparam int VAL_W   = 33;   // CORDIC x/y and Q3.30 products
  localparam int PHASE_W = 32;
  localparam int INNER_Q = 30;

  localparam logic signed [VAL_W-1:0] CORDIC_GAIN = 33'sd652032874;

  typedef enum logic {
    REQ_ROTATE = 1'b0,
    REQ_SET    = 1'b1
  } req_type_t;

  // Rounded atan(2^-i) in units of 2^32 per turn.
  function automatic logic signed [PHASE_W-1:0] atan_entry(input logic [4:0] idx);
    logic signed [PHASE_W-1:0] v;
    case (idx)
      5'd0:  v = 32'sd536870912;
      5'd1:  v = 32'sd316933406;
      5'd2:  v = 32'sd167458907;
      5'd3:  v = 32'sd85004756;
      5'd4:  v = 32'sd42667331;
      5'd5:  v = 32'sd21354465;
      5'd6:  v = 32'sd10680350;
      5'd7:  v = 32'sd5340245;
      5'd8:  v = 32'sd2670163;
      5'd9:  v = 32'sd1335087;
      5'd10: v = 32'sd667544;
      5'd11: v = 32'sd333772;
      5'd12: v = 32'sd166886;
      5'd13: v = 32'sd83443;
      5'd14: v = 32'sd41722;
      5'd15: v = 32'sd20861;
      5'd16: v = 32'sd10430;
      5'd17: v = 32'sd5215;
      5'd18: v = 32'sd2608;
      5'd19: v = 32'sd1304;
      5'd20: v = 32'sd652;
      5'd21: v = 32'sd326;
      5'd22: v = 32'sd163;
      5'd23: v = 32'sd81;
      5'd24: v = 32'sd41;
      5'd25: v = 32'sd20;
      5'd26: v = 32'sd10;
      5'd27: v = 32'sd5;
      5'd28: v = 32'sd3;
      5'd29: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/eaq_if.sv -----
// Handshake channel interfaces for the Euler angle to quaternion block.
// Depends on eaq_pkg for field widths.
interface eaq_req_if;
  import eaq_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [2:0]             set_mask;
  logic signed [IN_W-1:0] pitch_in;
  logic signed [IN_W-1:0] yaw_in;
  logic signed [IN_W-1:0] roll_in;
  modport source (output valid, req_type, set_mask, pitch_in, yaw_in, roll_in,
                  input ready);
  modport sink (input valid, req_type, set_mask, pitch_in, yaw_in, roll_in,
                output ready);
endinterface

interface eaq_rsp_if;
  import eaq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [QUAT_W-1:0] quat_x;
  logic signed [QUAT_W-1:0] quat_y;
  logic signed [QUAT_W-1:0] quat_z;
  logic signed [QUAT_W-1:0] quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// ----- rtl/eaq_cordic.sv -----
// One CORDIC lane: sine and cosine of a stored half angle, one step a cycle.
// Depends on eaq_pkg.
module eaq_cordic #(
  parameter int ANGLE_BITS   = eaq_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = eaq_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [ANGLE_BITS:0]               angle,
  output logic                              done,
  output logic signed [eaq_pkg::VAL_W-1:0]  cos_v,
  output logic signed [eaq_pkg::VAL_W-1:0]  sin_v
);
  import eaq_pkg::*;

  localparam int CW = $clog2(CORDIC_STEPS + 1);

  logic                      busy;
  logic [CW-1:0]             cnt;
  logic [1:0]                quad;
  logic signed [VAL_W-1:0]   x, y;
  logic signed [PHASE_W-1:0] z;
  logic [PHASE_W-1:0]        phase;
  logic signed [VAL_W-1:0]   dx, dy;
  logic signed [PHASE_W-1:0] at;

  assign phase = {angle, {(31 - ANGLE_BITS){1'b0}}};
  assign dx    = y >>> cnt;
  assign dy    = x >>> cnt;
  assign at    = atan_entry(5'(cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quad <= phase[31:30];
        x    <= CORDIC_GAIN;
        y    <= '0;
        z    <= {2'b00, phase[29:0]};
      end else if (busy) begin
        if (z >= 0) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    case (quad)
      2'd0:    begin cos_v = x;  sin_v = y;  end
      2'd1:    begin cos_v = -y; sin_v = x;  end
      2'd2:    begin cos_v = -x; sin_v = -y; end
      default: begin cos_v = y;  sin_v = -x; end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) start |=> busy);
  assert property (@(posedge clk) disable iff (rst) done |-> !busy);
  assert property (@(posedge clk) disable iff (rst) busy |-> cnt < CW'(CORDIC_STEPS));
endmodule

// ----- rtl/eaq_merge.sv -----
// Merge stage: pair products, triple products, then sum, round, saturate.
// Three registered stages. Depends on eaq_pkg.
module eaq_merge #(
  parameter int QUAT_FRAC_BITS = eaq_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [eaq_pkg::VAL_W-1:0]   cp, sp, cy, sy, cr, sr,
  output logic                               done,
  output logic signed [eaq_pkg::QUAT_W-1:0]  qx, qy, qz, qw
);
  import eaq_pkg::*;

  localparam int PROD_W = 2 * VAL_W;
  localparam int TRI_W  = PROD_W - INNER_Q;
  localparam int SUM_W  = TRI_W + 1;
  localparam int SH     = INNER_Q - QUAT_FRAC_BITS;
  localparam logic signed [SUM_W-1:0] RND =
    (SH > 0) ? (SUM_W'(1) <<< (SH > 0 ? SH - 1 : 0)) : '0;
  localparam logic signed [SUM_W-1:0] QMAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] QMIN = -SUM_W'(32768);

  logic                    v1, v2;
  logic signed [VAL_W-1:0] p_cysp, p_sycp, p_cycp, p_sysp, r_cr, r_sr;
  logic signed [TRI_W-1:0] t [8];
  logic signed [PROD_W-1:0] m_cysp, m_sycp, m_cycp, m_sysp;

  assign m_cysp = cy * sp;
  assign m_sycp = sy * cp;
  assign m_cycp = cy * cp;
  assign m_sysp = sy * sp;

  function automatic logic signed [TRI_W-1:0] tri_mul(
    input logic signed [VAL_W-1:0] a, input logic signed [VAL_W-1:0] b);
    logic signed [PROD_W-1:0] m;
    m = a * b;
    return TRI_W'(m >>> INNER_Q);
  endfunction

  function automatic logic signed [QUAT_W-1:0] to_q(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] r;
    r = (s + RND) >>> SH;
    if (r > QMAX) return QUAT_W'(32767);
    if (r < QMIN) return QUAT_W'(-32768);
    return QUAT_W'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p_cysp <= VAL_W'(m_cysp >>> INNER_Q);
      p_sycp <= VAL_W'(m_sycp >>> INNER_Q);
      p_cycp <= VAL_W'(m_cycp >>> INNER_Q);
      p_sysp <= VAL_W'(m_sysp >>> INNER_Q);
      r_cr   <= cr;
      r_sr   <= sr;
    end
    if (v1) begin
      t[0] <= tri_mul(p_cysp, r_cr);
      t[1] <= tri_mul(p_sycp, r_sr);
      t[2] <= tri_mul(p_sycp, r_cr);
      t[3] <= tri_mul(p_cysp, r_sr);
      t[4] <= tri_mul(p_cycp, r_sr);
      t[5] <= tri_mul(p_sysp, r_cr);
      t[6] <= tri_mul(p_cycp, r_cr);
      t[7] <= tri_mul(p_sysp, r_sr);
    end
    if (v2) begin
      qx <= to_q(SUM_W'(t[0]) + SUM_W'(t[1]));
      qy <= to_q(SUM_W'(t[2]) - SUM_W'(t[3]));
      qz <= to_q(SUM_W'(t[4]) - SUM_W'(t[5]));
      qw <= to_q(SUM_W'(t[6]) + SUM_W'(t[7]));
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |=> v1);
  assert property (@(posedge clk) disable iff (rst) v1 |=> done == 1'b0 && v2);
  assert property (@(posedge clk) disable iff (rst) done |-> $past(v2));
endmodule

// ----- rtl/euler_angle_accumulate_to_quaternion.sv -----
// Euler angle accumulator with quaternion output (top level).
// Depends on eaq_pkg, eaq_if, eaq_cordic, eaq_merge.
//
// Use: request channel carries a rotate (add signed deltas to pitch, yaw,
// roll, modulo two turns) or a set (replace masked angles, modulo one turn).
// Every request transaction yields exactly one response transaction with
// the quaternion x, y, z, w in Q1.15 (QUAT_FRAC_BITS fraction bits),
// saturated to 16 bits.
// From request to response valid, an item passes the three CORDIC lanes,
// stepping once a cycle, then three merge stages, one state handoff and
// the output register. A new item enters only after the previous one is
// through: ready is high only while no item is in flight, so a new item
// may enter while the previous response still waits in the output register.
// A stalled receiver holds the response steady; the finished next result
// waits until the output register is free.
// Reset (rst, synchronous) clears all angles to zero and drops the response valid.
module euler_angle_accumulate_to_quaternion #(
  parameter int ANGLE_BITS     = eaq_pkg::ANGLE_BITS_DEF,
  parameter int QUAT_FRAC_BITS = eaq_pkg::QUAT_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS   = eaq_pkg::CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  eaq_req_if.sink    req,
  eaq_rsp_if.source  rsp
);
  import eaq_pkg::*;

  localparam int AW = ANGLE_BITS + 1;

  typedef enum logic [1:0] {S_IDLE, S_CORD, S_MUL, S_FIN} state_t;

  state_t state;
  logic [AW-1:0] pitch_angle, yaw_angle, roll_angle;
  logic [AW-1:0] pitch_next, yaw_next, roll_next;
  logic [AW-1:0] p_ext, y_ext, r_ext;
  logic          accept, lane_start, merge_done, out_load;
  logic [2:0]    lane_done;
  logic signed [VAL_W-1:0]  cp, sp, cy, sy, cr, sr;
  logic signed [QUAT_W-1:0] qx, qy, qz, qw;

  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign lane_start = accept;
  assign out_load   = (state == S_FIN) && (!rsp.valid || rsp.ready);

  assign p_ext = AW'(req.pitch_in);
  assign y_ext = AW'(req.yaw_in);
  assign r_ext = AW'(req.roll_in);

  always_comb begin
    pitch_next = pitch_angle;
    yaw_next   = yaw_angle;
    roll_next  = roll_angle;
    if (accept) begin
      if (req.req_type == REQ_ROTATE) begin
        pitch_next = pitch_angle + p_ext;
        yaw_next   = yaw_angle + y_ext;
        roll_next  = roll_angle + r_ext;
      end else begin
        if (req.set_mask[0]) pitch_next = {1'b0, p_ext[ANGLE_BITS-1:0]};
        if (req.set_mask[1]) yaw_next   = {1'b0, y_ext[ANGLE_BITS-1:0]};
        if (req.set_mask[2]) roll_next  = {1'b0, r_ext[ANGLE_BITS-1:0]};
      end
    end
  end

  eaq_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_p (
    .clk, .rst, .start(lane_start), .angle(pitch_next), .done(lane_done[0]),
    .cos_v(cp), .sin_v(sp));
  eaq_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_y (
    .clk, .rst, .start(lane_start), .angle(yaw_next), .done(lane_done[1]),
    .cos_v(cy), .sin_v(sy));
  eaq_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_r (
    .clk, .rst, .start(lane_start), .angle(roll_next), .done(lane_done[2]),
    .cos_v(cr), .sin_v(sr));

  eaq_merge #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_merge (
    .clk, .rst, .start(state == S_CORD && lane_done[0]),
    .cp, .sp, .cy, .sy, .cr, .sr,
    .done(merge_done), .qx, .qy, .qz, .qw);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp.valid   <= 1'b0;
      pitch_angle <= '0;
      yaw_angle   <= '0;
      roll_angle  <= '0;
    end else begin
      pitch_angle <= pitch_next;
      yaw_angle   <= yaw_next;
      roll_angle  <= roll_next;
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (accept) state <= S_CORD;
        S_CORD: if (lane_done[0]) state <= S_MUL;
        S_MUL:  if (merge_done) state <= S_FIN;
        S_FIN: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.quat_x <= qx;
      rsp.quat_y <= qy;
      rsp.quat_z <= qz;
      rsp.quat_w <= qw;
    end
  end

  assert property (@(posedge clk) disable iff (rst) accept |=> state == S_CORD);
  assert property (@(posedge clk) disable iff (rst)
    lane_done[0] |-> lane_done[1] && lane_done[2]);
  assert property (@(posedge clk) disable iff (rst) merge_done |-> state == S_MUL);
  assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && rsp.valid && !rsp.ready |=> state == S_FIN && $stable(rsp.quat_x));
endmodule

// ----- tb/euler_angle_accumulate_to_quaternion_tb.sv -----
// Testbench for the Euler angle accumulator with quaternion output.
// Depends on eaq_pkg, eaq_if and the block; predicts each quaternion and checks it.
`timescale 1ns / 1ps
module euler_angle_accumulate_to_quaternion_tb;
  import eaq_pkg::*;

  localparam int ABITS = ANGLE_BITS_DEF;
  localparam int QFRAC = QUAT_FRAC_BITS_DEF;
  localparam int STEPS = CORDIC_STEPS_DEF;

  typedef struct packed {
    req_type_t              kind;
    logic [2:0]             mask;
    logic signed [IN_W-1:0] pitch;
    logic signed [IN_W-1:0] yaw;
    logic signed [IN_W-1:0] roll;
  } angle_cmd_t;

  typedef struct packed {
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
    logic signed [QUAT_W-1:0] w;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  eaq_req_if req ();
  eaq_rsp_if rsp ();

  euler_angle_accumulate_to_quaternion u_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  angle_cmd_t cmd_q[$];
  quat_t      quat_q[$];
  int         fails = 0;
  bit         calm  = 1'b0;   // stretch with no idling
  bit         in_fire = 1'b0; // request transaction at the last rising edge
  logic [ABITS:0] pitch_acc = '0, yaw_acc = '0, roll_acc = '0;

  initial forever #1 clk = ~clk;

  function automatic longint fshift(longint v, int s);
    return v >>> s;   // arithmetic shift on a signed value is a floor
  endfunction

  task automatic half_sincos(input logic [ABITS:0] ang, output longint c, output longint s);
    logic [31:0] phase;
    longint x, y, z, dx, dy;
    phase = 32'(ang) << (31 - ABITS);
    z = longint'(phase[29:0]);
    x = 652032874;
    y = 0;
    for (int i = 0; i < STEPS && i < 30; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_entry(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_entry(5'(i)));
      end
    end
    case (phase[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic longint tri3(longint a, longint b, longint c);
    return fshift(fshift(a * b, INNER_Q) * c, INNER_Q);
  endfunction

  function automatic logic [15:0] to_q(longint v);
    int sh;
    sh = INNER_Q - QFRAC;
    if (sh > 0) v = fshift(v + (longint'(1) << (sh - 1)), sh);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic predict_quat(input angle_cmd_t t);
    longint cp, sp, cy, sy, cr, sr;
    quat_t q;
    if (t.kind == REQ_ROTATE) begin
      pitch_acc += (ABITS+1)'(t.pitch);
      yaw_acc   += (ABITS+1)'(t.yaw);
      roll_acc  += (ABITS+1)'(t.roll);
    end else begin
      if (t.mask[0]) pitch_acc = {1'b0, t.pitch[ABITS-1:0]};
      if (t.mask[1]) yaw_acc   = {1'b0, t.yaw[ABITS-1:0]};
      if (t.mask[2]) roll_acc  = {1'b0, t.roll[ABITS-1:0]};
    end
    half_sincos(pitch_acc, cp, sp);
    half_sincos(yaw_acc, cy, sy);
    half_sincos(roll_acc, cr, sr);
    q.x = to_q(tri3(cy, sp, cr) + tri3(sy, cp, sr));
    q.y = to_q(tri3(sy, cp, cr) - tri3(cy, sp, sr));
    q.z = to_q(tri3(cy, cp, sr) - tri3(sy, sp, cr));
    q.w = to_q(tri3(cy, cp, cr) + tri3(sy, sp, sr));
    quat_q.push_back(q);
  endtask

  function automatic angle_cmd_t mk(req_type_t k, logic [2:0] m, int p, int y, int r);
    angle_cmd_t t;
    t.kind = k; t.mask = m;
    t.pitch = IN_W'(p); t.yaw = IN_W'(y); t.roll = IN_W'(r);
    return t;
  endfunction

  function automatic int rand_angle();
    case ($urandom_range(0, 5))
      0: return -65536;
      1: return 65535;
      2: return $urandom_range(0, 16) * 4096 - 32768;
      3: return int'($urandom_range(0, 200)) - 100;
      default: return int'($urandom_range(0, 131071)) - 65536;
    endcase
  endfunction

  // driver
  angle_cmd_t cur;
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || in_fire) begin
      // previous transaction (if any) went at the last rising edge
      if (cmd_q.size() > 0 && (calm || $urandom_range(0, 99) >= 11)) begin
        cur = cmd_q.pop_front();
        req.valid    <= 1'b1;
        req.req_type <= cur.kind;
        req.set_mask <= cur.mask;
        req.pitch_in <= cur.pitch;
        req.yaw_in   <= cur.yaw;
        req.roll_in  <= cur.roll;
      end else begin
        req.valid <= 1'b0;
      end
    end
    rsp.ready <= rst ? 1'b0 : (calm || $urandom_range(0, 99) >= 11);
  end

  // monitor
  quat_t got, want;
  always @(posedge clk) begin
    in_fire = !rst && req.valid && req.ready;
    if (!rst && req.valid && req.ready)
      predict_quat(mk(req_type_t'(req.req_type), req.set_mask, req.pitch_in,
                      req.yaw_in, req.roll_in));
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.quat_x, rsp.quat_y, rsp.quat_z, rsp.quat_w};
      if (quat_q.size() == 0) begin
        $error("unexpected quaternion transaction");
        fails++;
      end else begin
        want = quat_q.pop_front();
        if (got.x !== want.x) begin $error("quat_x exp %0d got %0d", want.x, got.x); fails++; end
        if (got.y !== want.y) begin $error("quat_y exp %0d got %0d", want.y, got.y); fails++; end
        if (got.z !== want.z) begin $error("quat_z exp %0d got %0d", want.z, got.z); fails++; end
        if (got.w !== want.w) begin $error("quat_w exp %0d got %0d", want.w, got.w); fails++; end
      end
    end
  end

  initial begin
    req.valid = 1'b0; req.req_type = 1'b0; req.set_mask = '0;
    req.pitch_in = '0; req.yaw_in = '0; req.roll_in = '0;
    rsp.ready = 1'b0;
    // directed: zero, extremes, set masks with negatives, full-scale w
    cmd_q.push_back(mk(REQ_ROTATE, 3'd0, 0, 0, 0));
    cmd_q.push_back(mk(REQ_ROTATE, 3'd7, 65535, 65535, 65535));
    cmd_q.push_back(mk(REQ_ROTATE, 3'd5, -65536, -65536, -65536));
    cmd_q.push_back(mk(REQ_ROTATE, 3'd0, 1, -1, 65535));
    cmd_q.push_back(mk(REQ_SET, 3'd7, 0, 0, 0));
    cmd_q.push_back(mk(REQ_SET, 3'd1, -1, 5, 5));
    cmd_q.push_back(mk(REQ_SET, 3'd2, 7, -65536, 7));
    cmd_q.push_back(mk(REQ_SET, 3'd4, 9, 9, -16384));
    cmd_q.push_back(mk(REQ_SET, 3'd0, 123, 456, 789));
    cmd_q.push_back(mk(REQ_SET, 3'd7, 65535, 65535, 65535));
    cmd_q.push_back(mk(REQ_SET, 3'd7, 16384, 32768, 49152));
    cmd_q.push_back(mk(REQ_ROTATE, 3'd0, 65535, 65535, 65535));
    cmd_q.push_back(mk(REQ_SET, 3'd3, 32768, -32768, 0));
    cmd_q.push_back(mk(REQ_SET, 3'd6, 0, 8192, 8192));
    cmd_q.push_back(mk(REQ_ROTATE, 3'd2, -65536, 65535, -1));
    cmd_q.push_back(mk(REQ_SET, 3'd7, -65536, -65536, -65536));
    repeat (1200)
      cmd_q.push_back(mk(req_type_t'($urandom_range(0, 2) == 0), 3'($urandom_range(0, 7)),
                         rand_angle(), rand_angle(), rand_angle()));
    repeat (6) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    wait (cmd_q.size() < 900);
    calm = 1'b1;
    wait (cmd_q.size() < 700);
    calm = 1'b0;
    wait (cmd_q.size() == 0 && !req.valid);
    wait (quat_q.size() == 0);
    repeat (STEPS + 20) @(posedge clk);
    if (fails == 0 && quat_q.size() == 0)
      $display("euler_angle_accumulate_to_quaternion_tb: PASS");
    else
      $display("euler_angle_accumulate_to_quaternion_tb: FAIL");
    $finish;
  end

  initial begin
    #400000;
    $display("euler_angle_accumulate_to_quaternion_tb: FAIL");
    $finish;
  end
endmodule
